/* src/tes_pkg.sv */
package tes_pkg;

    localparam int MAX_SEGMENTS_DEF = 16;
    localparam int TICK_RATE_DEF    = 200;
    localparam int MS_PER_S         = 1000;

    localparam logic [7:0] REPEAT_FOREVER = 8'd255;

    localparam logic [1:0] MODE_TICK = 2'd0;
    localparam logic [1:0] MODE_LOAD = 2'd1;
    localparam logic [1:0] MODE_PLAY = 2'd2;
    localparam logic [1:0] MODE_STOP = 2'd3;

    localparam logic [1:0] ACT_NONE    = 2'd0;
    localparam logic [1:0] ACT_TONE    = 2'd1;
    localparam logic [1:0] ACT_SILENCE = 2'd2;

    localparam logic REG_SEGMENT_COUNT = 1'b0;
    localparam logic REG_REPEAT_LIMIT  = 1'b1;

    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;

    localparam int DIV_LANES = 2;
    localparam int DIV_NUM_W = 32;
    localparam int DIV_DEN_W = 16;
    localparam int LANE_FREQ = 0;
    localparam int LANE_DUTY = 1;

    // ticks = ((ms * TICK_RATE) >> 3) * ceil(2^30 / 125) >> 30, exact for products below 2^26
    localparam int LEN_NUM_W     = 26;
    localparam int LEN_PRE_SHIFT = 3;
    localparam int LEN_DIV       = MS_PER_S >> LEN_PRE_SHIFT;
    localparam int LEN_SHIFT     = 30;
    localparam int LEN_RECIP_W   = 24;
    localparam int LEN_RECIP     = ((1 << LEN_SHIFT) + LEN_DIV - 1) / LEN_DIV;
    localparam int LEN_PROD_W    = LEN_NUM_W - LEN_PRE_SHIFT + LEN_RECIP_W;

    typedef struct packed {
        logic [1:0]  mode;
        logic [3:0]  segment_slot;
        logic [15:0] start_freq_hz;
        logic [15:0] end_freq_hz;
        logic [7:0]  start_duty;
        logic [7:0]  end_duty;
        logic [15:0] length_ms;
    } tes_in_t;

    typedef struct packed {
        logic [1:0]  action;
        logic [15:0] tone_freq_hz;
        logic [7:0]  tone_duty;
        logic        busy_res;
        logic        last_result;
    } tes_out_t;

    typedef struct packed {
        logic [15:0] start_freq_hz;
        logic [15:0] end_freq_hz;
        logic [7:0]  start_duty;
        logic [7:0]  end_duty;
        logic [15:0] length_ms;
    } seg_entry_t;

    typedef struct packed {
        logic capture;
        logic decode;
        logic rd_seg;
        logic rd_len;
        logic mul;
        logic div_start;
        logic commit;
        logic emit_first;
        logic emit_second;
    } dp_cmd_t;

    typedef struct packed {
        logic [1:0] mode;
        logic       running;
        logic       play_ok;
        logic       div_busy;
        logic       out_free;
        logic       finished;
    } dp_sts_t;

endpackage

/* src/tes_div.sv */
module tes_div (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   start,
    input  logic [tes_pkg::DIV_LANES-1:0][tes_pkg::DIV_NUM_W-1:0] num,
    input  logic [tes_pkg::DIV_LANES-1:0][tes_pkg::DIV_DEN_W-1:0] den,
    output logic                                   busy,
    output logic [tes_pkg::DIV_LANES-1:0][tes_pkg::DIV_NUM_W-1:0] quot
);
    import tes_pkg::*;

    localparam int CNT_W = $clog2(DIV_NUM_W + 1);

    logic                                  busy_reg;
    logic [CNT_W-1:0]                      cnt_reg;
    logic [DIV_LANES-1:0][DIV_NUM_W-1:0]   acc_reg;
    logic [DIV_LANES-1:0][DIV_DEN_W-1:0]   rem_reg;
    logic [DIV_LANES-1:0][DIV_DEN_W-1:0]   den_reg;
    logic [DIV_LANES-1:0][DIV_NUM_W-1:0]   acc_next;
    logic [DIV_LANES-1:0][DIV_DEN_W-1:0]   rem_next;
    logic [DIV_LANES-1:0][DIV_DEN_W:0]     shifted;
    logic [DIV_LANES-1:0][DIV_DEN_W:0]     diff;
    logic [DIV_LANES-1:0]                  ge;

    // restoring division, one quotient bit per lane per cycle
    always_comb begin
        for (int l = 0; l < DIV_LANES; l++) begin
            shifted[l]  = {rem_reg[l], acc_reg[l][DIV_NUM_W-1]};
            ge[l]       = shifted[l] >= {1'b0, den_reg[l]};
            diff[l]     = shifted[l] - {1'b0, den_reg[l]};
            rem_next[l] = ge[l] ? diff[l][DIV_DEN_W-1:0] : shifted[l][DIV_DEN_W-1:0];
            acc_next[l] = {acc_reg[l][DIV_NUM_W-2:0], ge[l]};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (start) begin
            busy_reg <= 1'b1;
            cnt_reg  <= CNT_W'(DIV_NUM_W);
        end else if (busy_reg) begin
            cnt_reg <= cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1)) begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            acc_reg <= num;
            rem_reg <= '0;
            den_reg <= den;
        end else if (busy_reg) begin
            acc_reg <= acc_next;
            rem_reg <= rem_next;
        end
    end

    assign busy = busy_reg;
    assign quot = acc_reg;

endmodule

/* src/tes_dp.sv */
module tes_dp #(
    parameter int MAX_SEGMENTS = tes_pkg::MAX_SEGMENTS_DEF,
    parameter int TICK_RATE    = tes_pkg::TICK_RATE_DEF
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  tes_pkg::tes_in_t s_item,
    input  logic             m_ready,
    output logic             m_valid,
    output tes_pkg::tes_out_t m_item,
    input  logic [4:0]       segment_count,
    input  logic [7:0]       repeat_limit,
    input  tes_pkg::dp_cmd_t cmd,
    output tes_pkg::dp_sts_t sts
);
    import tes_pkg::*;

    localparam int IDX_W = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;

    seg_entry_t mem [MAX_SEGMENTS];

    tes_in_t          item_reg;
    logic [IDX_W-1:0] cur_reg;
    logic [15:0]      tick_reg;
    logic [15:0]      seglen_reg;
    logic [7:0]       passes_reg;
    logic             running_reg;

    seg_entry_t       rd_data_reg;
    seg_entry_t       seg_reg;

    logic [IDX_W-1:0] plan_nx_reg, plan_nx_next;
    logic [IDX_W-1:0] len_addr_reg, len_addr_next;
    logic             plan_bnd_reg, plan_bnd_next;
    logic             plan_fin_reg, plan_fin_next;
    logic             plan_inc_reg, plan_inc_next;

    logic [31:0]      pf0_reg, pf1_reg, plen_reg;
    logic [23:0]      pd0_reg, pd1_reg;
    logic [LEN_PROD_W-1:0] len_prod_reg;

    tes_out_t         res_reg;
    logic             fin_reg;
    logic             m_valid_reg;
    tes_out_t         m_item_reg;

    logic [16:0]      nt;
    logic [IDX_W:0]   nx_w;
    logic [31:0]      eff_count;
    logic             at_end;
    logic             slot_ok;
    logic [15:0]      rem_t;
    logic [IDX_W-1:0] rd_addr;

    logic                                div_busy;
    logic [DIV_LANES-1:0][DIV_NUM_W-1:0] div_num;
    logic [DIV_LANES-1:0][DIV_DEN_W-1:0] div_den;
    logic [DIV_LANES-1:0][DIV_NUM_W-1:0] div_quot;
    logic [15:0]      fq;
    logic [7:0]       dq;
    logic [15:0]      lq;
    logic [15:0]      len_val;

    // end-of-segment / end-of-table plan for the current tick
    always_comb begin
        nt        = {1'b0, tick_reg} + 17'd1;
        nx_w      = {1'b0, cur_reg} + (IDX_W + 1)'(1);
        eff_count = (32'(segment_count) > 32'(MAX_SEGMENTS)) ? 32'(MAX_SEGMENTS)
                                                             : 32'(segment_count);
        at_end    = 32'(nx_w) >= eff_count;
        plan_bnd_next = nt >= {1'b0, seglen_reg};
        plan_nx_next  = nx_w[IDX_W-1:0];
        plan_fin_next = 1'b0;
        plan_inc_next = 1'b0;
        if (plan_bnd_next && at_end) begin
            if (repeat_limit == REPEAT_FOREVER) begin
                plan_nx_next = '0;
            end else if (passes_reg < repeat_limit) begin
                plan_inc_next = 1'b1;
                plan_nx_next  = '0;
            end else begin
                plan_fin_next = 1'b1;
            end
        end
        len_addr_next = (item_reg.mode == MODE_PLAY) ? '0 : plan_nx_next;
    end

    assign slot_ok = 32'(item_reg.segment_slot) < 32'(MAX_SEGMENTS);
    assign rem_t   = seglen_reg - tick_reg;
    assign rd_addr = cmd.rd_seg ? cur_reg : len_addr_reg;

    always_ff @(posedge aclk) begin
        if (cmd.decode && item_reg.mode == MODE_LOAD && slot_ok) begin
            mem[IDX_W'(item_reg.segment_slot)] <= '{
                start_freq_hz: item_reg.start_freq_hz,
                end_freq_hz:   item_reg.end_freq_hz,
                start_duty:    item_reg.start_duty,
                end_duty:      item_reg.end_duty,
                length_ms:     item_reg.length_ms
            };
        end
        if (cmd.rd_seg || cmd.rd_len) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            item_reg <= s_item;
        end
        if (cmd.decode) begin
            plan_nx_reg  <= plan_nx_next;
            len_addr_reg <= len_addr_next;
            plan_bnd_reg <= plan_bnd_next;
            plan_fin_reg <= plan_fin_next;
            plan_inc_reg <= plan_inc_next;
        end
        if (cmd.rd_len) begin
            seg_reg <= rd_data_reg;
        end
        if (cmd.mul) begin
            pf0_reg  <= 32'(seg_reg.start_freq_hz) * 32'(rem_t);
            pf1_reg  <= 32'(seg_reg.end_freq_hz) * 32'(tick_reg);
            pd0_reg  <= 24'(seg_reg.start_duty) * 24'(rem_t);
            pd1_reg  <= 24'(seg_reg.end_duty) * 24'(tick_reg);
            plen_reg <= 32'(rd_data_reg.length_ms) * 32'(TICK_RATE);
        end
        if (cmd.div_start) begin
            len_prod_reg <= LEN_PROD_W'(plen_reg[LEN_NUM_W-1:LEN_PRE_SHIFT])
                            * LEN_PROD_W'(LEN_RECIP);
        end
    end

    always_comb begin
        div_num[LANE_FREQ] = pf0_reg + pf1_reg;
        div_num[LANE_DUTY] = 32'(pd0_reg + pd1_reg);
        div_den[LANE_FREQ] = seglen_reg;
        div_den[LANE_DUTY] = seglen_reg;
    end

    tes_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cmd.div_start),
        .num     (div_num),
        .den     (div_den),
        .busy    (div_busy),
        .quot    (div_quot)
    );

    assign fq      = div_quot[LANE_FREQ][15:0];
    assign dq      = div_quot[LANE_DUTY][7:0];
    assign lq      = len_prod_reg[LEN_SHIFT +: 16];
    assign len_val = (lq == 16'd0) ? 16'd1 : lq;

    // playback state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_reg     <= '0;
            tick_reg    <= '0;
            seglen_reg  <= 16'd1;
            passes_reg  <= '0;
            running_reg <= 1'b0;
            fin_reg     <= 1'b0;
        end else if (cmd.decode) begin
            fin_reg <= 1'b0;
            if (item_reg.mode == MODE_STOP) begin
                running_reg <= 1'b0;
            end
        end else if (cmd.commit) begin
            if (item_reg.mode == MODE_PLAY) begin
                cur_reg     <= '0;
                tick_reg    <= '0;
                passes_reg  <= '0;
                seglen_reg  <= len_val;
                running_reg <= 1'b1;
            end else begin
                fin_reg <= plan_fin_reg;
                if (plan_bnd_reg) begin
                    tick_reg <= '0;
                    cur_reg  <= plan_nx_reg;
                    if (plan_inc_reg) begin
                        passes_reg <= passes_reg + 8'd1;
                    end
                    if (plan_fin_reg) begin
                        running_reg <= 1'b0;
                    end else begin
                        seglen_reg <= len_val;
                    end
                end else begin
                    tick_reg <= tick_reg + 16'd1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.decode) begin
            res_reg.action       <= (item_reg.mode == MODE_STOP) ? ACT_SILENCE : ACT_NONE;
            res_reg.tone_freq_hz <= '0;
            res_reg.tone_duty    <= '0;
        end else if (cmd.commit && item_reg.mode == MODE_TICK) begin
            res_reg.action       <= (fq != 16'd0) ? ACT_TONE : ACT_SILENCE;
            res_reg.tone_freq_hz <= fq;
            res_reg.tone_duty    <= (fq != 16'd0) ? dq : 8'd0;
        end
        res_reg.busy_res    <= 1'b0;
        res_reg.last_result <= 1'b0;
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.emit_first || cmd.emit_second) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit_first) begin
            m_item_reg.action       <= res_reg.action;
            m_item_reg.tone_freq_hz <= res_reg.tone_freq_hz;
            m_item_reg.tone_duty    <= res_reg.tone_duty;
            m_item_reg.busy_res     <= running_reg;
            m_item_reg.last_result  <= !fin_reg;
        end else if (cmd.emit_second) begin
            m_item_reg.action       <= ACT_SILENCE;
            m_item_reg.tone_freq_hz <= '0;
            m_item_reg.tone_duty    <= '0;
            m_item_reg.busy_res     <= running_reg;
            m_item_reg.last_result  <= 1'b1;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;

    always_comb begin
        sts.mode     = item_reg.mode;
        sts.running  = running_reg;
        sts.play_ok  = segment_count != 5'd0;
        sts.div_busy = div_busy;
        sts.out_free = !m_valid_reg || m_ready;
        sts.finished = fin_reg;
    end

endmodule

/* src/tes_ctrl.sv */
module tes_ctrl (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  tes_pkg::dp_sts_t sts,
    output tes_pkg::dp_cmd_t cmd
);
    import tes_pkg::*;

    typedef enum logic [9:0] {
        S_IDLE     = 10'b0000000001,
        S_DECODE   = 10'b0000000010,
        S_RD_SEG   = 10'b0000000100,
        S_RD_LEN   = 10'b0000001000,
        S_MUL      = 10'b0000010000,
        S_DIV_GO   = 10'b0000100000,
        S_DIV_WAIT = 10'b0001000000,
        S_COMMIT   = 10'b0010000000,
        S_EMIT     = 10'b0100000000,
        S_EMIT2    = 10'b1000000000
    } state_t;

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        case (state_reg)
            S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.capture = 1'b1;
                    state_next  = S_DECODE;
                end
            end
            S_DECODE: begin
                cmd.decode = 1'b1;
                case (sts.mode)
                    MODE_PLAY: state_next = sts.play_ok ? S_RD_LEN : S_EMIT;
                    MODE_TICK: state_next = sts.running ? S_RD_SEG : S_EMIT;
                    default:   state_next = S_EMIT;
                endcase
            end
            S_RD_SEG: begin
                cmd.rd_seg = 1'b1;
                state_next = S_RD_LEN;
            end
            S_RD_LEN: begin
                cmd.rd_len = 1'b1;
                state_next = S_MUL;
            end
            S_MUL: begin
                cmd.mul    = 1'b1;
                state_next = S_DIV_GO;
            end
            S_DIV_GO: begin
                cmd.div_start = 1'b1;
                state_next    = S_DIV_WAIT;
            end
            S_DIV_WAIT: begin
                if (!sts.div_busy) begin
                    state_next = S_COMMIT;
                end
            end
            S_COMMIT: begin
                cmd.commit = 1'b1;
                state_next = S_EMIT;
            end
            S_EMIT: begin
                if (sts.out_free) begin
                    cmd.emit_first = 1'b1;
                    state_next     = sts.finished ? S_EMIT2 : S_IDLE;
                end
            end
            S_EMIT2: begin
                if (sts.out_free) begin
                    cmd.emit_second = 1'b1;
                    state_next      = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

/* src/tone_envelope_sequencer_core.sv */
// Tone envelope sequencer.
// Input channel (s_valid/s_ready/s_item) takes one item per command: tick, load
// segment, play or stop. Result channel (m_valid/m_ready/m_item) returns one
// result per item, two for the tick that ends playback (its result, then silence).
// Config over APB: segment_count at 0x0, repeat_limit at 0x4; pready is tied high.
// Load, stop, an idle tick and a play with segment_count 0 go from decode straight to the
// result step; play reads the segment length, then multiplies, divides and commits; a
// tick while playing also reads its segment first, and the tick that ends playback
// writes a second result. Play and tick run memory reads, one multiply stage, then a
// 32-step radix-2 divider for frequency and duty; the next segment length comes from a
// reciprocal multiply that overlaps the divide.
// One item is worked on at a time; s_ready rises again once the last result is
// in the output register.
// The output register holds a result until taken, so the next item is accepted
// while it waits; a stalled receiver stalls only the step that writes a result.
// Reset clears playback state, the registers (segment_count 1, repeat_limit 0)
// and the output valid; the segment table is not cleared and must be loaded
// before it is played.
module tone_envelope_sequencer_core #(
    parameter int MAX_SEGMENTS = tes_pkg::MAX_SEGMENTS_DEF,
    parameter int TICK_RATE    = tes_pkg::TICK_RATE_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  tes_pkg::tes_in_t             s_item,
    output logic                         m_valid,
    input  logic                         m_ready,
    output tes_pkg::tes_out_t            m_item,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [tes_pkg::PADDR_W-1:0]  paddr,
    input  logic [tes_pkg::PDATA_W-1:0]  pwdata,
    output logic [tes_pkg::PDATA_W-1:0]  prdata,
    output logic                         pready
);
    import tes_pkg::*;

    logic [4:0] segment_count_reg;
    logic [7:0] repeat_limit_reg;
    logic       reg_sel;
    dp_cmd_t    cmd;
    dp_sts_t    sts;

    assign pready  = 1'b1;
    assign reg_sel = paddr[2];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            segment_count_reg <= 5'd1;
            repeat_limit_reg  <= 8'd0;
        end else if (psel && penable && pwrite && pready) begin
            case (reg_sel)
                REG_SEGMENT_COUNT: segment_count_reg <= pwdata[4:0];
                REG_REPEAT_LIMIT:  repeat_limit_reg  <= pwdata[7:0];
                default:           segment_count_reg <= segment_count_reg;
            endcase
        end
    end

    always_comb begin
        case (reg_sel)
            REG_SEGMENT_COUNT: prdata = PDATA_W'(segment_count_reg);
            REG_REPEAT_LIMIT:  prdata = PDATA_W'(repeat_limit_reg);
            default:           prdata = '0;
        endcase
    end

    tes_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    tes_dp #(
        .MAX_SEGMENTS (MAX_SEGMENTS),
        .TICK_RATE    (TICK_RATE)
    ) u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_item        (s_item),
        .m_ready       (m_ready),
        .m_valid       (m_valid),
        .m_item        (m_item),
        .segment_count (segment_count_reg),
        .repeat_limit  (repeat_limit_reg),
        .cmd           (cmd),
        .sts           (sts)
    );

`ifndef SYNTHESIS
    a_tone_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_item.action == ACT_TONE |-> m_item.tone_freq_hz != 16'd0)
        else $error("tone result with zero frequency");

    a_quiet_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_item.action != ACT_TONE |->
            m_item.tone_freq_hz == 16'd0 && m_item.tone_duty == 8'd0)
        else $error("non-tone result carries tone data");

    a_first_of_two: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_item.last_result |-> !m_item.busy_res)
        else $error("non-final result while still playing");

    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("second item accepted while one is in work");
`endif

endmodule

/* tb/tb_top.sv */
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import tes_pkg::*;

    localparam int SETTLE_CYCLES  = 60;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int PHASES         = 5;
    localparam int PHASE_ITEMS    = 100;

    localparam int PH_COUNT [PHASES]     = '{16, 1, 0, 7, 16};
    localparam int PH_REPEAT [PHASES]    = '{0, 255, 3, 2, 255};
    localparam int PH_SEND_IDLE [PHASES] = '{0, 68, 0, 31, 0};
    localparam int PH_STALL [PHASES]     = '{0, 0, 68, 31, 0};

    class tone_tracker;
        bit [15:0] f_start [MAX_SEGMENTS_DEF];
        bit [15:0] f_end [MAX_SEGMENTS_DEF];
        bit [7:0]  d_start [MAX_SEGMENTS_DEF];
        bit [7:0]  d_end [MAX_SEGMENTS_DEF];
        bit [15:0] dur_ms [MAX_SEGMENTS_DEF];
        int unsigned seg_idx = 0;
        bit [15:0] tick_pos = 0;
        bit [15:0] seg_ticks = 1;
        bit [7:0]  passes = 0;
        bit        playing = 0;
        bit [4:0]  seg_count = 1;
        bit [7:0]  repeat_max = 0;
        tes_out_t  tones_due [$];
        int        failures = 0;

        function bit [15:0] length_of(int unsigned idx);
            longint unsigned n;
            n = 0;
            if (idx < MAX_SEGMENTS_DEF) n = dur_ms[idx];
            n = (n * TICK_RATE_DEF / MS_PER_S) & 64'hFFFF;
            return (n == 0) ? 16'd1 : n[15:0];
        endfunction

        function void queue_tone(logic [1:0] act, bit [15:0] f, bit [7:0] d, bit last);
            tes_out_t o;
            o.action       = act;
            o.tone_freq_hz = f;
            o.tone_duty    = d;
            o.busy_res     = playing;
            o.last_result  = last;
            tones_due.push_back(o);
        endfunction

        function void set_register(logic idx, logic [31:0] v);
            if (idx == REG_SEGMENT_COUNT) seg_count = v[4:0];
            else repeat_max = v[7:0];
        endfunction

        function void apply_command(tes_in_t it);
            longint unsigned total, t, freq, duty;
            int unsigned lim, nx;
            bit done;
            logic [1:0] act;
            case (it.mode)
                MODE_LOAD: begin
                    f_start[it.segment_slot] = it.start_freq_hz;
                    f_end[it.segment_slot]   = it.end_freq_hz;
                    d_start[it.segment_slot] = it.start_duty;
                    d_end[it.segment_slot]   = it.end_duty;
                    dur_ms[it.segment_slot]  = it.length_ms;
                    queue_tone(ACT_NONE, 0, 0, 1);
                end
                MODE_PLAY: begin
                    if (seg_count != 0) begin
                        seg_idx   = 0;
                        tick_pos  = 0;
                        passes    = 0;
                        seg_ticks = length_of(0);
                        playing   = 1;
                    end
                    queue_tone(ACT_NONE, 0, 0, 1);
                end
                MODE_STOP: begin
                    playing = 0;
                    queue_tone(ACT_SILENCE, 0, 0, 1);
                end
                MODE_TICK: begin
                    if (!playing) begin
                        queue_tone(ACT_NONE, 0, 0, 1);
                    end else begin
                        total = (seg_ticks == 0) ? 1 : seg_ticks;
                        t = (tick_pos < total) ? tick_pos : total - 1;
                        freq = (f_start[seg_idx] * (total - t) + f_end[seg_idx] * t) / total;
                        duty = (d_start[seg_idx] * (total - t) + d_end[seg_idx] * t) / total;
                        act = (freq > 0) ? ACT_TONE : ACT_SILENCE;
                        if (act == ACT_SILENCE) begin
                            freq = 0;
                            duty = 0;
                        end
                        done = 0;
                        if (longint'(tick_pos) + 1 >= total) begin
                            tick_pos = 0;
                            nx = seg_idx + 1;
                            lim = (seg_count > MAX_SEGMENTS_DEF) ? MAX_SEGMENTS_DEF : seg_count;
                            if (nx >= lim) begin
                                if (repeat_max == REPEAT_FOREVER) begin
                                    nx = 0;
                                end else if (passes < repeat_max) begin
                                    passes++;
                                    nx = 0;
                                end else begin
                                    playing = 0;
                                    done = 1;
                                end
                            end
                            seg_idx = nx;
                            if (!done) seg_ticks = length_of(nx);
                        end else begin
                            tick_pos = tick_pos + 16'd1;
                        end
                        queue_tone(act, freq[15:0], duty[7:0], !done);
                        if (done) queue_tone(ACT_SILENCE, 0, 0, 1);
                    end
                end
            endcase
        endfunction

        function void match_output(tes_out_t got);
            tes_out_t want;
            if (tones_due.size() == 0) begin
                failures++;
                if (failures <= 10)
                    $display("%0t: unexpected item act=%0d freq=%0d duty=%0d busy=%0d last=%0d",
                             $time, got.action, got.tone_freq_hz, got.tone_duty,
                             got.busy_res, got.last_result);
                return;
            end
            want = tones_due.pop_front();
            if (got.action !== want.action || got.tone_freq_hz !== want.tone_freq_hz ||
                got.tone_duty !== want.tone_duty || got.busy_res !== want.busy_res ||
                got.last_result !== want.last_result) begin
                failures++;
                if (failures <= 10)
                    $display("%0t: mismatch exp act=%0d freq=%0d duty=%0d busy=%0d last=%0d",
                             $time, want.action, want.tone_freq_hz, want.tone_duty,
                             want.busy_res, want.last_result,
                             "  got act=%0d freq=%0d duty=%0d busy=%0d last=%0d",
                             got.action, got.tone_freq_hz, got.tone_duty,
                             got.busy_res, got.last_result);
            end
        endfunction
    endclass

    logic                aclk    = 1'b0;
    logic                aresetn = 1'b0;
    logic                s_valid = 1'b0;
    logic                s_ready;
    tes_in_t             s_item  = '0;
    logic                m_valid;
    logic                m_ready = 1'b0;
    tes_out_t            m_item;
    logic                psel    = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite  = 1'b0;
    logic [PADDR_W-1:0]  paddr   = '0;
    logic [PDATA_W-1:0]  pwdata  = '0;
    logic [PDATA_W-1:0]  prdata;
    logic                pready;

    tone_tracker tracker;
    int send_idle = 0;
    int stall_pct = 0;
    int quiet = 0;

    tone_envelope_sequencer_core dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_item  (s_item),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_item  (m_item),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #2 aclk = ~aclk;

    always @(negedge aclk) begin
        m_ready <= ($urandom_range(0, 99) >= stall_pct);
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) tracker.match_output(m_item);
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || psel) begin
            quiet <= 0;
        end else if (quiet >= WATCHDOG_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end else begin
            quiet <= quiet + 1;
        end
    end

    function automatic tes_in_t scrambled(logic [1:0] mode);
        tes_in_t it;
        it.mode          = mode;
        it.segment_slot  = 4'($urandom_range(0, 15));
        it.start_freq_hz = 16'($urandom_range(0, 65535));
        it.end_freq_hz   = 16'($urandom_range(0, 65535));
        it.start_duty    = 8'($urandom_range(0, 255));
        it.end_duty      = 8'($urandom_range(0, 255));
        it.length_ms     = 16'($urandom_range(0, 65535));
        return it;
    endfunction

    function automatic tes_in_t seg_load(logic [3:0] slot, logic [15:0] f0, logic [15:0] f1,
                                         logic [7:0] d0, logic [7:0] d1, logic [15:0] dur);
        tes_in_t it;
        it = '{MODE_LOAD, slot, f0, f1, d0, d1, dur};
        return it;
    endfunction

    function automatic tes_in_t random_load(logic [3:0] slot);
        tes_in_t it;
        it = scrambled(MODE_LOAD);
        it.segment_slot = slot;
        if ($urandom_range(0, 99) < 15) begin
            it.start_freq_hz = 16'd0;
            it.end_freq_hz   = 16'($urandom_range(0, 3));
        end
        if ($urandom_range(0, 99) < 3) it.length_ms = 16'($urandom_range(0, 65535));
        else it.length_ms = 16'($urandom_range(0, 20));
        return it;
    endfunction

    task automatic send(tes_in_t it);
        @(negedge aclk);
        while ($urandom_range(0, 99) < send_idle) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_item  <= it;
        do @(posedge aclk); while (!s_ready);
        tracker.apply_command(it);
    endtask

    task automatic cfg_write(logic idx, logic [31:0] value);
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge aclk);
        penable <= 1'b1;
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        tracker.set_register(idx, value);
    endtask

    // drop valid, let every pending result drain, then give the core time to go idle
    task automatic settle();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (tracker.tones_due.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // loads, mostly a play, ticks with stray loads and stops, maybe a closing stop
    task automatic run_phase(int n);
        int sent;
        int ticks;
        int roll;
        sent = 0;
        while (sent < n) begin
            repeat ($urandom_range(0, 2)) begin
                send(random_load(4'($urandom_range(0, 15))));
                sent++;
            end
            if ($urandom_range(0, 9) == 0) send(scrambled(2'($urandom_range(0, 3))));
            else send(scrambled(MODE_PLAY));
            sent++;
            ticks = $urandom_range(1, 80);
            while (ticks > 0 && sent < n) begin
                roll = $urandom_range(0, 99);
                if (roll < 5) send(random_load(4'($urandom_range(0, 15))));
                else if (roll < 8) send(scrambled(MODE_STOP));
                else send(scrambled(MODE_TICK));
                sent++;
                ticks--;
            end
            if ($urandom_range(0, 9) < 3) begin
                send(scrambled(MODE_STOP));
                sent++;
            end
        end
    endtask

    initial begin
        int ph;
        tracker = new();
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        cfg_write(REG_SEGMENT_COUNT, 32'd3);
        cfg_write(REG_REPEAT_LIMIT, 32'd1);

        send(scrambled(MODE_TICK));
        send(scrambled(MODE_STOP));
        send(seg_load(4'd0, 16'hFFFF, 16'h0000, 8'hFF, 8'h00, 16'd10));
        send(seg_load(4'd1, 16'h0000, 16'h0000, 8'h00, 8'hFF, 16'd0));
        send(seg_load(4'd2, 16'd440, 16'd880, 8'd128, 8'd64, 16'd10));
        send(seg_load(4'd15, 16'hFFFF, 16'hFFFF, 8'hFF, 8'hFF, 16'hFFFF));
        send(scrambled(MODE_PLAY));
        // two passes of five ticks; the last one ends playback
        repeat (10) send(scrambled(MODE_TICK));
        send(scrambled(MODE_TICK));
        send(seg_load(4'd0, 16'd1, 16'hFFFF, 8'h00, 8'hFF, 16'hFFFF));
        send(scrambled(MODE_PLAY));
        send(scrambled(MODE_TICK));
        send(scrambled(MODE_TICK));
        send(scrambled(MODE_STOP));
        settle();

        for (ph = 0; ph < PHASES; ph++) begin
            cfg_write(REG_SEGMENT_COUNT, PH_COUNT[ph]);
            cfg_write(REG_REPEAT_LIMIT, PH_REPEAT[ph]);
            send_idle = PH_SEND_IDLE[ph];
            stall_pct = PH_STALL[ph];
            if (ph == 0) begin
                for (int s = 0; s < MAX_SEGMENTS_DEF; s++) send(random_load(4'(s)));
            end
            run_phase(PHASE_ITEMS);
            settle();
        end

        if (tracker.failures == 0 && tracker.tones_due.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
